@@ sv/lres_pkg.sv @@
// ----------------------------------------------------------------------------
// LED ring effect sequencer package
// Shared widths, codes, configuration and result types for the sequencer.
// ----------------------------------------------------------------------------
package lres_pkg;

  // Number of pixels along one half of the collapse path.
  localparam int PATH_LEN = 16;
  localparam int PL_W     = $clog2(PATH_LEN + 1);

  localparam int MS_W   = 12;
  localparam int FMS_W  = 8;
  localparam int Q_W    = MS_W;
  localparam int NUM_W  = 2 * MS_W + PL_W;
  localparam int DCNT_W = $clog2(Q_W);

  localparam int NCFG   = 8;
  localparam int CFG_AW = $clog2(NCFG) + 2;
  localparam int CFG_IW = $clog2(NCFG);

  localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

  // Opcodes.
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_ACTIVATE   = 3'd1;
  localparam logic [2:0] OP_DEACTIVATE = 3'd2;
  localparam logic [2:0] OP_BEGIN      = 3'd3;
  localparam logic [2:0] OP_CANCEL     = 3'd4;
  localparam logic [2:0] OP_COMMIT     = 3'd5;
  localparam logic [2:0] OP_NONE       = 3'd0;

  // Ring status codes.
  localparam logic [2:0] ST_OFF          = 3'd0;
  localparam logic [2:0] ST_ACTIVATING   = 3'd1;
  localparam logic [2:0] ST_ON           = 3'd2;
  localparam logic [2:0] ST_DEACTIVATING = 3'd3;
  localparam logic [2:0] ST_COLLAPSING   = 3'd4;
  localparam logic [2:0] ST_WAITING      = 3'd5;
  localparam logic [2:0] ST_PREVIEW      = 3'd6;
  localparam logic [2:0] ST_APPLYING     = 3'd7;

  // Animation phase codes.
  localparam logic [2:0] PH_EXPAND       = 3'd0;
  localparam logic [2:0] PH_COLLAPSE_OFF = 3'd1;
  localparam logic [2:0] PH_COLLAPSE_EDG = 3'd2;
  localparam logic [2:0] PH_HOLD_EDGE    = 3'd3;
  localparam logic [2:0] PH_EDGE_BLEND   = 3'd4;
  localparam logic [2:0] PH_EDGE_FADE    = 3'd5;

  // Mode codes.
  localparam logic [1:0] MODE_REGULAR = 2'd0;
  localparam logic [1:0] MODE_MAX     = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_FRAME      = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ACTIVATE   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DEACTIVATE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_COLLAPSE   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DECISION   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_EDGE_FADE  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_EDGE_BLEND = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_EXPAND     = 3'd7;

  // Configuration reset values.
  localparam logic [FMS_W-1:0] RST_FRAME_MS      = 8'd20;
  localparam logic [MS_W-1:0]  RST_ACTIVATE_MS   = 12'd350;
  localparam logic [MS_W-1:0]  RST_DEACTIVATE_MS = 12'd350;
  localparam logic [MS_W-1:0]  RST_COLLAPSE_MS   = 12'd300;
  localparam logic [MS_W-1:0]  RST_DECISION_MS   = 12'd750;
  localparam logic [MS_W-1:0]  RST_EDGE_FADE_MS  = 12'd200;
  localparam logic [MS_W-1:0]  RST_EDGE_BLEND_MS = 12'd200;
  localparam logic [MS_W-1:0]  RST_EXPAND_MS     = 12'd400;

  typedef struct packed {
    logic [FMS_W-1:0] frame_ms;
    logic [MS_W-1:0]  activate_ms;
    logic [MS_W-1:0]  deactivate_ms;
    logic [MS_W-1:0]  collapse_ms;
    logic [MS_W-1:0]  decision_ms;
    logic [MS_W-1:0]  edge_fade_ms;
    logic [MS_W-1:0]  edge_blend_ms;
    logic [MS_W-1:0]  expand_ms;
  } cfg_t;

  // Datapath operations, one per cycle.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_TICK,
    DP_APPLY,
    DP_MUL,
    DP_DIV,
    DP_FINISH,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   res_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_tick;
    logic       cmd_ok;
    logic       cancel_div;
    logic       running;
    logic       step_done;
    logic       total_zero;
    logic [1:0] n_res;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]      phase;
    logic [MS_W-1:0] elapsed_ms;
    logic [MS_W-1:0] total_ms;
    logic [1:0]      primary_mode;
    logic [1:0]      secondary_mode;
  } frame_t;

  typedef struct packed {
    logic       accepted;
    logic       frame_valid;
    frame_t     frm;
    logic [2:0] status;
    logic [1:0] active_mode;
    logic       last_result;
  } res_t;

endpackage

@@ sv/lres_dp.sv @@
// ----------------------------------------------------------------------------
// Sequencer datapath
// Ring state, step timing, frame buffer and the cancel offset divider.
// ----------------------------------------------------------------------------
module lres_dp (
  input  logic             clk,
  input  logic             rst,
  input  lres_pkg::cfg_t   cfg,
  input  logic [2:0]       in_opcode,
  input  logic [1:0]       in_mode,
  input  lres_pkg::dp_cmd_t cmd,
  output lres_pkg::dp_stat_t stat,
  output lres_pkg::res_t   res
);
  import lres_pkg::*;

  logic [2:0]      ring_status, ring_status_next;
  logic [1:0]      current_mode, current_mode_next;
  logic [1:0]      pending_mode, pending_mode_next;
  logic [2:0]      running_cmd, running_cmd_next;
  logic [2:0]      step_phase, step_phase_next;
  logic [MS_W-1:0] step_elapsed, step_elapsed_next;
  logic [MS_W-1:0] step_total, step_total_next;
  logic [MS_W-1:0] since_ms, since_ms_next;
  logic [1:0]      frame_primary, frame_primary_next;
  logic [1:0]      frame_secondary, frame_secondary_next;
  logic [2:0]      op_q, op_q_next;
  logic [1:0]      mode_q, mode_q_next;
  logic            accepted, accepted_next;
  logic [1:0]      fcount, fcount_next;
  logic [NUM_W-1:0] rem, rem_next;
  logic [NUM_W-1:0] dsh, dsh_next;
  logic [Q_W-1:0]  quot, quot_next;
  frame_t          fbuf [2];

  logic            ld_en;
  logic [2:0]      ld_phase;
  logic [MS_W-1:0] ld_total;
  logic [MS_W-1:0] ld_off;
  logic [MS_W:0]   since_sum;
  logic [MS_W:0]   el_sum;
  logic            emit_en;
  frame_t          emit_frm;
  logic            mode_ok;
  logic            changing;

  assign since_sum = {1'b0, since_ms} + (MS_W+1)'(cfg.frame_ms);
  assign el_sum    = {1'b0, step_elapsed} + (MS_W+1)'(cfg.frame_ms);
  assign mode_ok   = mode_q <= MODE_MAX;
  assign changing  = (ring_status == ST_COLLAPSING) || (ring_status == ST_WAITING);

  always_comb begin
    ring_status_next     = ring_status;
    current_mode_next    = current_mode;
    pending_mode_next    = pending_mode;
    running_cmd_next     = running_cmd;
    step_phase_next      = step_phase;
    step_elapsed_next    = step_elapsed;
    step_total_next      = step_total;
    since_ms_next        = since_ms;
    frame_primary_next   = frame_primary;
    frame_secondary_next = frame_secondary;
    op_q_next            = op_q;
    mode_q_next          = mode_q;
    accepted_next        = accepted;
    fcount_next          = fcount;
    rem_next             = rem;
    dsh_next             = dsh;
    quot_next            = quot;
    ld_en                = 1'b0;
    ld_phase             = PH_EXPAND;
    ld_total             = '0;
    ld_off               = '0;

    unique case (cmd.op)
      DP_LOAD: begin
        op_q_next     = in_opcode;
        mode_q_next   = in_mode;
        fcount_next   = 2'd0;
        accepted_next = 1'b0;
      end
      DP_TICK: begin
        since_ms_next = since_sum[MS_W] ? MS_MAX : since_sum[MS_W-1:0];
        if (running_cmd != OP_NONE) begin
          step_elapsed_next = (el_sum < {1'b0, step_total}) ? el_sum[MS_W-1:0]
                                                            : step_total;
        end
      end
      DP_APPLY: begin
        accepted_next    = 1'b1;
        running_cmd_next = op_q;
        ld_en            = 1'b1;
        frame_secondary_next = MODE_NONE;
        priority case (op_q)
          OP_ACTIVATE: begin
            frame_primary_next = mode_q;
            ring_status_next   = ST_ACTIVATING;
            ld_phase           = PH_EXPAND;
            ld_total           = cfg.activate_ms;
          end
          OP_DEACTIVATE: begin
            frame_primary_next = current_mode;
            ring_status_next   = ST_DEACTIVATING;
            ld_phase           = PH_COLLAPSE_OFF;
            ld_total           = cfg.deactivate_ms;
          end
          OP_BEGIN: begin
            pending_mode_next    = mode_q;
            since_ms_next        = '0;
            frame_primary_next   = current_mode;
            frame_secondary_next = mode_q;
            ring_status_next     = ST_COLLAPSING;
            ld_phase             = PH_COLLAPSE_EDG;
            ld_total             = cfg.collapse_ms;
          end
          OP_CANCEL: begin
            frame_primary_next = current_mode;
            ring_status_next   = ST_DEACTIVATING;
            if (since_ms < cfg.collapse_ms) begin
              // Resume the off-collapse at the point matching the edge collapse.
              ld_phase = PH_COLLAPSE_OFF;
              ld_total = cfg.deactivate_ms;
              ld_off   = quot;
            end else begin
              ld_phase = PH_EDGE_FADE;
              ld_total = cfg.edge_fade_ms;
            end
          end
          default: begin
            frame_primary_next = pending_mode;
            ring_status_next   = ST_APPLYING;
            ld_phase           = PH_EXPAND;
            ld_total           = cfg.expand_ms;
          end
        endcase
      end
      DP_MUL: begin
        rem_next  = NUM_W'(since_ms) * NUM_W'(PATH_LEN - 1) * NUM_W'(cfg.deactivate_ms);
        dsh_next  = (NUM_W'(cfg.collapse_ms) * NUM_W'(PATH_LEN)) << (Q_W - 1);
        quot_next = '0;
      end
      DP_DIV: begin
        if (rem >= dsh) begin
          rem_next  = rem - dsh;
          quot_next = {quot[Q_W-2:0], 1'b1};
        end else begin
          quot_next = {quot[Q_W-2:0], 1'b0};
        end
        dsh_next = dsh >> 1;
      end
      DP_FINISH: begin
        priority case (running_cmd)
          OP_ACTIVATE, OP_COMMIT: begin
            current_mode_next = frame_primary;
            ring_status_next  = ST_ON;
            running_cmd_next  = OP_NONE;
          end
          OP_BEGIN: begin
            if (step_phase == PH_COLLAPSE_EDG) begin
              ring_status_next = ST_WAITING;
              ld_en            = 1'b1;
              ld_phase         = PH_HOLD_EDGE;
              ld_total         = (cfg.decision_ms > cfg.collapse_ms)
                                 ? cfg.decision_ms - cfg.collapse_ms : '0;
            end else if (step_phase == PH_HOLD_EDGE) begin
              ring_status_next = ST_PREVIEW;
              ld_en            = 1'b1;
              ld_phase         = PH_EDGE_BLEND;
              ld_total         = cfg.edge_blend_ms;
            end else begin
              running_cmd_next = OP_NONE;
            end
          end
          default: begin
            ring_status_next = ST_OFF;
            running_cmd_next = OP_NONE;
          end
        endcase
      end
      DP_EMIT, DP_NONE: begin
      end
    endcase

    if (ld_en) begin
      step_phase_next   = ld_phase;
      step_total_next   = ld_total;
      step_elapsed_next = (ld_off < ld_total) ? ld_off : ld_total;
    end

    // A tick shows the advanced elapsed time; an opening frame shows the step as loaded.
    emit_en  = ((cmd.op == DP_TICK) && (running_cmd != OP_NONE)) || (cmd.op == DP_EMIT);
    emit_frm = '{phase: step_phase, elapsed_ms: step_elapsed_next, total_ms: step_total,
                 primary_mode: frame_primary, secondary_mode: frame_secondary};
    if (emit_en && (fcount != 2'd2)) begin
      fcount_next = fcount + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_status     <= ST_OFF;
      current_mode    <= MODE_REGULAR;
      pending_mode    <= MODE_REGULAR;
      running_cmd     <= OP_NONE;
      step_phase      <= PH_EXPAND;
      step_elapsed    <= '0;
      step_total      <= '0;
      since_ms        <= '0;
      frame_primary   <= MODE_REGULAR;
      frame_secondary <= MODE_NONE;
      accepted        <= 1'b0;
      fcount          <= 2'd0;
    end else begin
      ring_status     <= ring_status_next;
      current_mode    <= current_mode_next;
      pending_mode    <= pending_mode_next;
      running_cmd     <= running_cmd_next;
      step_phase      <= step_phase_next;
      step_elapsed    <= step_elapsed_next;
      step_total      <= step_total_next;
      since_ms        <= since_ms_next;
      frame_primary   <= frame_primary_next;
      frame_secondary <= frame_secondary_next;
      accepted        <= accepted_next;
      fcount          <= fcount_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q   <= op_q_next;
    mode_q <= mode_q_next;
    rem    <= rem_next;
    dsh    <= dsh_next;
    quot   <= quot_next;
    if (emit_en && (fcount != 2'd2)) begin
      fbuf[fcount[0]] <= emit_frm;
    end
  end

  // Status towards the controller.
  always_comb begin
    stat.is_tick    = op_q == OP_TICK;
    stat.cancel_div = (op_q == OP_CANCEL) && (since_ms < cfg.collapse_ms);
    stat.running    = running_cmd != OP_NONE;
    stat.step_done  = step_elapsed >= step_total;
    stat.total_zero = step_total == '0;
    stat.n_res      = (op_q == OP_TICK) ? fcount : 2'd1;
    priority case (op_q)
      OP_ACTIVATE:   stat.cmd_ok = mode_ok && (ring_status == ST_OFF);
      OP_DEACTIVATE: stat.cmd_ok = ring_status == ST_ON;
      OP_BEGIN:      stat.cmd_ok = mode_ok && (ring_status == ST_ON) &&
                                   (mode_q != current_mode);
      OP_CANCEL:     stat.cmd_ok = changing && (since_ms < cfg.decision_ms);
      OP_COMMIT:     stat.cmd_ok = (changing || (ring_status == ST_PREVIEW)) &&
                                   (since_ms >= cfg.decision_ms);
      default:       stat.cmd_ok = 1'b0;
    endcase
  end

  // Result item selected by the controller.
  always_comb begin
    res.accepted    = accepted;
    res.frame_valid = {1'b0, cmd.res_idx} < fcount;
    if (res.frame_valid) begin
      res.frm = fbuf[cmd.res_idx];
    end else begin
      res.frm = '{phase: PH_EXPAND, elapsed_ms: '0, total_ms: '0,
                  primary_mode: MODE_REGULAR, secondary_mode: MODE_NONE};
    end
    res.status      = ring_status;
    res.active_mode = current_mode;
    res.last_result = {1'b0, cmd.res_idx} == (stat.n_res - 2'd1);
  end

endmodule

@@ sv/lres_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sequencer controller
// Walks one input item through decode, divide, step chaining and result output.
// ----------------------------------------------------------------------------
module lres_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               push_valid,
  input  logic               push_ready,
  output lres_pkg::dp_cmd_t  cmd,
  input  lres_pkg::dp_stat_t stat
);
  import lres_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_APPLY,
    S_CHECK,
    S_OPEN,
    S_OUT
  } state_t;

  state_t            state, state_next;
  logic [DCNT_W-1:0] cnt, cnt_next;
  logic              k, k_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    cmd.op     = DP_NONE;
    cmd.res_idx = k;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_tick) begin
          cmd.op     = DP_TICK;
          state_next = S_CHECK;
        end else if (!stat.cmd_ok) begin
          state_next = S_OUT;
        end else if (stat.cancel_div) begin
          cmd.op     = DP_MUL;
          cnt_next   = '0;
          state_next = S_DIV;
        end else begin
          cmd.op     = DP_APPLY;
          state_next = S_OPEN;
        end
      end
      S_DIV: begin
        cmd.op = DP_DIV;
        if (cnt == DCNT_W'(Q_W - 1)) begin
          state_next = S_APPLY;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_APPLY: begin
        cmd.op     = DP_APPLY;
        state_next = S_OPEN;
      end
      S_CHECK: begin
        if (stat.running && stat.step_done) begin
          cmd.op     = DP_FINISH;
          state_next = S_OPEN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OPEN: begin
        // Steps of zero length end at once; the first real step shows its frame.
        if (stat.running && stat.total_zero) begin
          cmd.op = DP_FINISH;
        end else if (stat.running) begin
          cmd.op     = DP_EMIT;
          state_next = S_OUT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.n_res == 2'd0) begin
          state_next = S_IDLE;
        end else begin
          push_valid = 1'b1;
          if (push_ready) begin
            if ({1'b0, k} == (stat.n_res - 2'd1)) begin
              k_next     = 1'b0;
              state_next = S_IDLE;
            end else begin
              k_next = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      k     <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
    end
  end

endmodule

@@ sv/lres_outq.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue between the sequencer and the result stream.
// ----------------------------------------------------------------------------
module lres_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  lres_pkg::res_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lres_pkg::res_t pop_data
);
  import lres_pkg::*;

  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ sv/led_ring_effect_sequencer.sv @@
// ----------------------------------------------------------------------------
// LED ring effect sequencer
// Command and frame-tick sequencer for LED ring on/off and mode-change effects.
// ----------------------------------------------------------------------------
// Usage. Each beat on the slave stream is one item: a tick, standing for one
// frame period, or a command (activate, deactivate, begin, cancel or commit a
// mode change). Every command gives exactly one result beat; a tick gives none,
// one or two, the last of them flagged by tlast. tuser says whether the beat
// carries a frame descriptor. The APB port sets the frame period and the phase
// durations and should only be written while no item is in flight.
// Timing. An item is taken only when the sequencer is idle and occupies it
// through decode, step chaining when zero-length steps are skipped, and the
// output of each result beat. A cancel that resumes the off-collapse
// additionally runs a restoring divider for the scaled offset; that divider
// sets the worst case.
// Reset. rst clears the ring to off with the regular mode, no step running and
// the registers at their defaults; there is no clearing pass.
// Stalls. Results go through a two-entry queue, so the sequencer finishes an
// item and takes the next while the receiver holds off tready; it waits only
// when the queue is full.
// ----------------------------------------------------------------------------
module led_ring_effect_sequencer (
  input  logic        clk,
  input  logic        rst,
  // Item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // opcode[2:0], mode[4:3], zero[7:5]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // accepted[0], phase[3:1], elapsed_ms[15:4],
                                 // total_ms[27:16], primary_mode[29:28],
                                 // secondary_mode[31:30], status[34:32],
                                 // active_mode[36:35], zero[39:37]
  output logic        m_tuser,   // frame_valid[0]
  output logic        m_tlast,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lres_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lres_pkg::*;

  cfg_t      cfg;
  logic      cfg_wr;
  logic [CFG_IW-1:0] cfg_idx;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  res_t      res;
  res_t      out_res;
  logic      push_valid;
  logic      push_ready;

  // Register file. Writes complete in the APB access cycle; reads are direct.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_ms      <= RST_FRAME_MS;
      cfg.activate_ms   <= RST_ACTIVATE_MS;
      cfg.deactivate_ms <= RST_DEACTIVATE_MS;
      cfg.collapse_ms   <= RST_COLLAPSE_MS;
      cfg.decision_ms   <= RST_DECISION_MS;
      cfg.edge_fade_ms  <= RST_EDGE_FADE_MS;
      cfg.edge_blend_ms <= RST_EDGE_BLEND_MS;
      cfg.expand_ms     <= RST_EXPAND_MS;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_FRAME:      cfg.frame_ms      <= pwdata[FMS_W-1:0];
        CFG_ACTIVATE:   cfg.activate_ms   <= pwdata[MS_W-1:0];
        CFG_DEACTIVATE: cfg.deactivate_ms <= pwdata[MS_W-1:0];
        CFG_COLLAPSE:   cfg.collapse_ms   <= pwdata[MS_W-1:0];
        CFG_DECISION:   cfg.decision_ms   <= pwdata[MS_W-1:0];
        CFG_EDGE_FADE:  cfg.edge_fade_ms  <= pwdata[MS_W-1:0];
        CFG_EDGE_BLEND: cfg.edge_blend_ms <= pwdata[MS_W-1:0];
        CFG_EXPAND:     cfg.expand_ms     <= pwdata[MS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_FRAME:      prdata = 32'(cfg.frame_ms);
      CFG_ACTIVATE:   prdata = 32'(cfg.activate_ms);
      CFG_DEACTIVATE: prdata = 32'(cfg.deactivate_ms);
      CFG_COLLAPSE:   prdata = 32'(cfg.collapse_ms);
      CFG_DECISION:   prdata = 32'(cfg.decision_ms);
      CFG_EDGE_FADE:  prdata = 32'(cfg.edge_fade_ms);
      CFG_EDGE_BLEND: prdata = 32'(cfg.edge_blend_ms);
      CFG_EXPAND:     prdata = 32'(cfg.expand_ms);
    endcase
  end

  lres_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  lres_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_opcode (s_tdata[2:0]),
    .in_mode   (s_tdata[4:3]),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res)
  );

  lres_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (res),
    .pop_valid  (m_tvalid),
    .pop_ready  (m_tready),
    .pop_data   (out_res)
  );

  // Result beat layout, highest field first.
  assign m_tdata = {3'b000, out_res.active_mode, out_res.status,
                    out_res.frm.secondary_mode, out_res.frm.primary_mode,
                    out_res.frm.total_ms, out_res.frm.elapsed_ms,
                    out_res.frm.phase, out_res.accepted};
  assign m_tuser = out_res.frame_valid;
  assign m_tlast = out_res.last_result;

`ifndef SYNTHESIS
  // The sequencer handles one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item taken while the previous one is still in progress");

  // Elapsed time never runs past the phase length.
  a_elapsed_le_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:4] <= m_tdata[27:16]))
    else $error("elapsed time beyond phase total");

  // A beat without a frame carries the neutral descriptor.
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> ((m_tdata[29:1] == '0) && (m_tdata[31:30] == MODE_NONE)))
    else $error("frame fields set on a beat without a frame");
`endif

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// LED ring effect sequencer testbench
// Drives command and tick beats into the sequencer through its item stream and
// programs the phase timings through the register port. A cycle-free model of
// the ring, kept here, predicts every result beat. A monitor compares the beats
// on the result stream, field by field, with those predictions in order. The
// run starts with a short directed sequence, then goes through several timing
// settings. Each setting gets a random mix of on/off and mode-change flows,
// under changing amounts of idling on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import lres_pkg::*;

  // Cycles allowed without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT   = 3000;
  // Cycles left for an item that gives no result to finish inside the block.
  localparam int SETTLE_CYCLES = 40;
  // Items planned for each random timing setting.
  localparam int ITEMS_PER_SET = 105;
  localparam int RANDOM_SETS   = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // opcode[2:0], mode[4:3], zero[7:5]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // accepted[0], phase[3:1], elapsed_ms[15:4],
                                  // total_ms[27:16], primary_mode[29:28],
                                  // secondary_mode[31:30], status[34:32],
                                  // active_mode[36:35], zero[39:37]
  logic        m_tuser;           // frame_valid[0]
  logic        m_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  led_ring_effect_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ring model. It mirrors the timing registers as last written and holds the
  // ring's status, modes and the running animation step. Every item taken by
  // the block goes through ring_step, which appends the result beats that
  // item must produce to result_due.
  // --------------------------------------------------------------------------
  cfg_t cfg = '{frame_ms: RST_FRAME_MS, activate_ms: RST_ACTIVATE_MS,
                deactivate_ms: RST_DEACTIVATE_MS, collapse_ms: RST_COLLAPSE_MS,
                decision_ms: RST_DECISION_MS, edge_fade_ms: RST_EDGE_FADE_MS,
                edge_blend_ms: RST_EDGE_BLEND_MS, expand_ms: RST_EXPAND_MS};

  logic [2:0]      ring_st   = ST_OFF;
  logic [1:0]      cur_mode  = MODE_REGULAR;
  logic [1:0]      pend_mode = MODE_REGULAR;
  logic [2:0]      run_op    = OP_NONE;     // opcode of the command still animating
  logic [2:0]      step_ph   = PH_EXPAND;
  logic [MS_W-1:0] step_el   = '0;
  logic [MS_W-1:0] step_tot  = '0;
  logic [MS_W-1:0] since_ms  = '0;          // time since the mode change began
  logic [1:0]      frm_prim  = MODE_REGULAR;
  logic [1:0]      frm_sec   = MODE_NONE;

  frame_t frames_out[$];   // frames produced by the item being modelled
  res_t   result_due[$];   // beats still owed by the block, oldest first

  int errors = 0;
  int items_taken = 0;
  int cmds_taken = 0;
  int twin_frames = 0;
  int beats_checked = 0;
  int settings_used = 0;

  task automatic load_step(input logic [2:0] ph, input logic [MS_W-1:0] tot,
                           input int unsigned offset);
    step_ph  = ph;
    step_tot = tot;
    step_el  = (offset < tot) ? offset[MS_W-1:0] : tot;
  endtask

  task automatic emit_frame();
    frame_t f;
    f.phase          = step_ph;
    f.elapsed_ms     = step_el;
    f.total_ms       = step_tot;
    f.primary_mode   = frm_prim;
    f.secondary_mode = frm_sec;
    if (frames_out.size() < 2) frames_out.push_back(f);
  endtask

  // Closes the current step and moves the running command on to its next one.
  task automatic finish_step();
    case (run_op)
      OP_ACTIVATE, OP_COMMIT: begin
        cur_mode = frm_prim;
        ring_st  = ST_ON;
        run_op   = OP_NONE;
      end
      OP_BEGIN: begin
        if (step_ph == PH_COLLAPSE_EDG) begin
          // The hold lasts until the decision point; it vanishes when the
          // decision time does not exceed the collapse time.
          ring_st = ST_WAITING;
          load_step(PH_HOLD_EDGE, (cfg.decision_ms > cfg.collapse_ms) ?
                    cfg.decision_ms - cfg.collapse_ms : '0, 0);
        end else if (step_ph == PH_HOLD_EDGE) begin
          ring_st = ST_PREVIEW;
          load_step(PH_EDGE_BLEND, cfg.edge_blend_ms, 0);
        end else begin
          run_op = OP_NONE;
        end
      end
      default: begin
        ring_st = ST_OFF;
        run_op  = OP_NONE;
      end
    endcase
  endtask

  // Steps of zero length are passed over without a frame of their own.
  task automatic open_step();
    while (run_op != OP_NONE && step_tot == '0) finish_step();
    if (run_op != OP_NONE) emit_frame();
  endtask

  task automatic ring_step(input logic [2:0] op, input logic [1:0] mode);
    logic            ok;
    logic            changing;
    logic [MS_W:0]   sum;
    longint unsigned num;
    longint unsigned den;
    int unsigned     offset;
    int              n;
    res_t            r;
    frames_out.delete();
    ok       = 1'b0;
    changing = (ring_st == ST_COLLAPSING) || (ring_st == ST_WAITING);
    if (op == OP_TICK) begin
      sum      = since_ms + cfg.frame_ms;
      since_ms = (sum > MS_MAX) ? MS_MAX : sum[MS_W-1:0];
      if (run_op != OP_NONE) begin
        sum     = step_el + cfg.frame_ms;
        step_el = (sum < step_tot) ? sum[MS_W-1:0] : step_tot;
        emit_frame();
        if (step_el >= step_tot) begin
          finish_step();
          open_step();
        end
      end
    end else begin
      case (op)
        OP_ACTIVATE: begin
          if (mode <= MODE_MAX && ring_st == ST_OFF) begin
            ok       = 1'b1;
            frm_prim = mode;
            frm_sec  = MODE_NONE;
            ring_st  = ST_ACTIVATING;
            load_step(PH_EXPAND, cfg.activate_ms, 0);
          end
        end
        OP_DEACTIVATE: begin
          if (ring_st == ST_ON) begin
            ok       = 1'b1;
            frm_prim = cur_mode;
            frm_sec  = MODE_NONE;
            ring_st  = ST_DEACTIVATING;
            load_step(PH_COLLAPSE_OFF, cfg.deactivate_ms, 0);
          end
        end
        OP_BEGIN: begin
          if (mode <= MODE_MAX && ring_st == ST_ON && mode != cur_mode) begin
            ok        = 1'b1;
            pend_mode = mode;
            since_ms  = '0;
            frm_prim  = cur_mode;
            frm_sec   = mode;
            ring_st   = ST_COLLAPSING;
            load_step(PH_COLLAPSE_EDG, cfg.collapse_ms, 0);
          end
        end
        OP_CANCEL: begin
          if (changing && since_ms < cfg.decision_ms) begin
            ok       = 1'b1;
            frm_prim = cur_mode;
            frm_sec  = MODE_NONE;
            ring_st  = ST_DEACTIVATING;
            if (since_ms < cfg.collapse_ms) begin
              // Resume the off-collapse at the point the edge collapse reached.
              num    = 64'(since_ms) * 64'(PATH_LEN - 1) * 64'(cfg.deactivate_ms);
              den    = 64'(cfg.collapse_ms) * 64'(PATH_LEN);
              offset = (den != 0) ? int'(num / den) : 0;
              load_step(PH_COLLAPSE_OFF, cfg.deactivate_ms, offset);
            end else begin
              load_step(PH_EDGE_FADE, cfg.edge_fade_ms, 0);
            end
          end
        end
        OP_COMMIT: begin
          if ((changing || ring_st == ST_PREVIEW) && since_ms >= cfg.decision_ms) begin
            ok       = 1'b1;
            frm_prim = pend_mode;
            frm_sec  = MODE_NONE;
            ring_st  = ST_APPLYING;
            load_step(PH_EXPAND, cfg.expand_ms, 0);
          end
        end
        default: ;
      endcase
      if (ok) begin
        run_op = op;
        open_step();
        cmds_taken++;
      end
    end

    // A command always answers once; a tick answers once per frame it made.
    n = (op == OP_TICK) ? frames_out.size() : 1;
    if (op == OP_TICK && n == 2) twin_frames++;
    for (int k = 0; k < n; k++) begin
      r          = '0;
      r.accepted = ok;
      if (k < frames_out.size()) begin
        r.frame_valid = 1'b1;
        r.frm         = frames_out[k];
      end else begin
        r.frm.secondary_mode = MODE_NONE;
      end
      r.status      = ring_st;
      r.active_mode = cur_mode;
      r.last_result = (k == n - 1);
      result_due.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Item driver. Beats wait in item_q until the driver puts them on the bus.
  // gap_pct is the chance, per cycle, that the sender stays idle although it
  // has something to send. A beat is modelled at the edge at which it is taken.
  // --------------------------------------------------------------------------
  logic [7:0] item_q[$];
  int gap_pct = 0;
  int stall_pct = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        ring_step(s_tdata[2:0], s_tdata[4:3]);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= item_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. tready is dropped at random, at the rate in stall_pct, and
  // every beat taken is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (m_tvalid && m_tready) begin
        beats_checked++;
        if (result_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = result_due.pop_front();
          check_field("accepted", want.accepted, m_tdata[0]);
          check_field("frame_valid", want.frame_valid, m_tuser);
          check_field("phase", want.frm.phase, m_tdata[3:1]);
          check_field("elapsed_ms", want.frm.elapsed_ms, m_tdata[15:4]);
          check_field("total_ms", want.frm.total_ms, m_tdata[27:16]);
          check_field("primary_mode", want.frm.primary_mode, m_tdata[29:28]);
          check_field("secondary_mode", want.frm.secondary_mode, m_tdata[31:30]);
          check_field("status", want.status, m_tdata[34:32]);
          check_field("active_mode", want.active_mode, m_tdata[36:35]);
          check_field("last_result", want.last_result, m_tlast);
        end
      end
    end
  end

  // Watchdog: any beat on either stream or any register write counts as
  // progress; a long enough silence means the block has hung.
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d beats still owed",
                 $time, QUIET_LIMIT, result_due.size());
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  int planned = 0;

  task automatic push_item(input logic [2:0] op, input logic [1:0] mode);
    item_q.push_back({3'b000, mode, op});
    planned++;
  endtask

  task automatic push_ticks(input int count);
    repeat (count) push_item(OP_TICK, 2'($urandom));
  endtask

  // Ticks needed for a step of the given length to run out, sometimes with one
  // spare tick so that idle ticks also occur.
  function automatic int steps_for(input int unsigned dur);
    int f;
    f = cfg.frame_ms;
    return (dur + f - 1) / f + $urandom_range(0, 1);
  endfunction

  function automatic logic [MS_W-1:0] pick_ms(input int f, input int zero_pct);
    int hi;
    hi = (f * 12 > 4095) ? 4095 : f * 12;
    return ($urandom_range(0, 99) < zero_pct) ? '0 : MS_W'($urandom_range(1, hi));
  endfunction

  // One flow: switch the ring on, then either switch it off or start a mode
  // change that ends in an early cancel, a late cancel or a commit. The tick
  // counts aim at the windows that each command needs, so most commands land
  // where they are allowed; a few random beats and an early commit add noise.
  task automatic plan_flow();
    logic [1:0] m;
    logic [1:0] m2;
    int route;
    int lo;
    int hi;
    int f;
    f  = cfg.frame_ms;
    m  = 2'($urandom_range(0, 2));
    m2 = ($urandom_range(0, 19) == 0) ? MODE_NONE : 2'((m + $urandom_range(1, 2)) % 3);
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) push_item(3'($urandom_range(0, 7)), 2'($urandom));
    push_item(OP_ACTIVATE, m);
    push_ticks(steps_for(cfg.activate_ms));
    route = $urandom_range(0, 9);
    if (route < 2) begin
      push_item(OP_DEACTIVATE, 2'($urandom));
      push_ticks(steps_for(cfg.deactivate_ms));
    end else begin
      push_item(OP_BEGIN, m2);
      if (route < 4) begin
        // Cancel while the edge collapse is still under way.
        hi = (cfg.collapse_ms == 0) ? 0 : (cfg.collapse_ms - 1) / f;
        push_ticks($urandom_range(0, hi));
        push_item(OP_CANCEL, 2'($urandom));
        push_ticks(steps_for(cfg.deactivate_ms));
      end else if (route < 6) begin
        // Cancel after the collapse but before the decision point.
        lo = steps_for(cfg.collapse_ms);
        hi = (cfg.decision_ms == 0) ? 0 : (cfg.decision_ms - 1) / f;
        if (hi < lo) hi = lo;
        push_ticks($urandom_range(lo, hi));
        push_item(OP_CANCEL, 2'($urandom));
        push_ticks(steps_for(cfg.edge_fade_ms));
      end else begin
        lo = (cfg.decision_ms + f - 1) / f;
        if (route == 9 && lo > 0) begin
          // A commit one frame short of the decision point is refused.
          push_ticks(lo - 1);
          push_item(OP_COMMIT, 2'($urandom));
          push_ticks(1);
        end else begin
          push_ticks(lo + $urandom_range(0, 3));
        end
        push_item(OP_COMMIT, 2'($urandom));
        push_ticks(steps_for(cfg.expand_ms));
        push_item(OP_DEACTIVATE, 2'($urandom));
        push_ticks(steps_for(cfg.deactivate_ms));
      end
    end
  endtask

  // Register write: setup cycle, then access cycle; the model's copy of the
  // register follows once the write edge has passed. Bits above the register
  // width carry random values, which the block must ignore.
  task automatic write_reg(input int idx, input logic [MS_W-1:0] val);
    logic [31:0] word;
    word = {20'($urandom), val};
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_AW'(idx * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CFG_FRAME:      cfg.frame_ms      = word[FMS_W-1:0];
      CFG_ACTIVATE:   cfg.activate_ms   = word[MS_W-1:0];
      CFG_DEACTIVATE: cfg.deactivate_ms = word[MS_W-1:0];
      CFG_COLLAPSE:   cfg.collapse_ms   = word[MS_W-1:0];
      CFG_DECISION:   cfg.decision_ms   = word[MS_W-1:0];
      CFG_EDGE_FADE:  cfg.edge_fade_ms  = word[MS_W-1:0];
      CFG_EDGE_BLEND: cfg.edge_blend_ms = word[MS_W-1:0];
      CFG_EXPAND:     cfg.expand_ms     = word[MS_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every queued beat has been taken and every predicted result
  // has arrived, then leaves time for an item that gives no result to finish.
  task automatic drain();
    while (item_q.size() != 0 || s_tvalid || result_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [MS_W-1:0] vals [NCFG];
    int f;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset timings: unused opcodes, commands refused in
    // the off state, an invalid mode, an idle tick, then a real activation.
    settings_used++;
    push_item(3'($urandom_range(6, 7)), MODE_NONE);
    push_item(3'(OP_COMMIT + 3'd2), MODE_REGULAR);
    push_item(OP_DEACTIVATE, MODE_REGULAR);
    push_item(OP_BEGIN, 2'd1);
    push_item(OP_CANCEL, 2'd2);
    push_item(OP_COMMIT, MODE_REGULAR);
    push_item(OP_ACTIVATE, MODE_NONE);
    push_item(OP_TICK, MODE_REGULAR);
    push_item(OP_ACTIVATE, 2'd1);
    push_item(OP_TICK, 2'd2);
    drain();

    // Long frames against short steps. The activate length becomes zero, so
    // the next activation ends at once without a frame; the decision time
    // equals the collapse time, so the hold step is skipped; the longest
    // off-collapse length gives a large resumed offset on the early cancel.
    settings_used++;
    vals[CFG_FRAME]      = {4'($urandom), 8'd255};
    vals[CFG_ACTIVATE]   = '0;
    vals[CFG_DEACTIVATE] = MS_MAX;
    vals[CFG_COLLAPSE]   = 12'd300;
    vals[CFG_DECISION]   = 12'd300;
    vals[CFG_EDGE_FADE]  = 12'd1;
    vals[CFG_EDGE_BLEND] = 12'd200;
    vals[CFG_EXPAND]     = MS_MAX;
    for (int i = 0; i < NCFG; i++) write_reg(i, vals[i]);
    push_ticks(2);                       // activation running since reset ends
    push_item(OP_BEGIN, 2'd1);           // same mode as active: refused
    push_item(OP_BEGIN, 2'd2);
    push_ticks(1);
    push_item(OP_CANCEL, MODE_REGULAR);  // inside the collapse window
    push_ticks(4);
    push_item(OP_ACTIVATE, MODE_REGULAR);
    push_item(OP_BEGIN, 2'd2);
    push_ticks(2);                       // second tick ends collapse, starts blend
    push_item(OP_COMMIT, 2'd3);
    drain();

    // Random part. Each timing setting is paired with one way of idling: none,
    // a mostly idle sender, a mostly stalling receiver, then both moderately.
    // Every setting starts only after the block has gone quiet.
    for (int set = 0; set < RANDOM_SETS; set++) begin
      case (set)
        0: begin
          vals[CFG_FRAME] = {4'($urandom), 8'd255};
          for (int i = 1; i < NCFG; i++) vals[i] = MS_MAX;
        end
        1: begin
          vals[CFG_FRAME]      = {4'($urandom), RST_FRAME_MS};
          vals[CFG_ACTIVATE]   = RST_ACTIVATE_MS;
          vals[CFG_DEACTIVATE] = RST_DEACTIVATE_MS;
          vals[CFG_COLLAPSE]   = RST_COLLAPSE_MS;
          vals[CFG_DECISION]   = RST_DECISION_MS;
          vals[CFG_EDGE_FADE]  = RST_EDGE_FADE_MS;
          vals[CFG_EDGE_BLEND] = RST_EDGE_BLEND_MS;
          vals[CFG_EXPAND]     = RST_EXPAND_MS;
        end
        2: begin
          vals[CFG_FRAME] = {4'($urandom), 8'd1};
          for (int i = 1; i < NCFG; i++) vals[i] = 12'd1;
        end
        3: begin
          // Zero collapse time sends every cancel down the edge fade path.
          f = $urandom_range(8, 255);
          vals[CFG_FRAME]      = {4'($urandom), 8'(f)};
          vals[CFG_ACTIVATE]   = '0;
          vals[CFG_DEACTIVATE] = pick_ms(f, 0);
          vals[CFG_COLLAPSE]   = '0;
          vals[CFG_DECISION]   = pick_ms(f, 0);
          vals[CFG_EDGE_FADE]  = pick_ms(f, 0);
          vals[CFG_EDGE_BLEND] = '0;
          vals[CFG_EXPAND]     = '0;
        end
        default: begin
          f = $urandom_range(1, 255);
          vals[CFG_FRAME] = {4'($urandom), 8'(f)};
          for (int i = 1; i < NCFG; i++) vals[i] = pick_ms(f, (set > 5) ? 10 : 0);
        end
      endcase
      for (int i = 0; i < NCFG; i++) write_reg(i, vals[i]);
      settings_used++;
      case (set % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 76; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 76; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      planned = 0;
      while (planned < ITEMS_PER_SET) plan_flow();
      drain();
    end

    $display("Run covered %0d items (%0d commands accepted, %0d ticks giving two frames)",
             items_taken, cmds_taken, twin_frames);
    $display("and %0d result beats over %0d timing settings.", beats_checked, settings_used);
    if (errors == 0 && result_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
